[hw/rtl/mpf_pkg.sv]
// mpf_pkg: shared types and constants of the maximal pattern filter
// used by mpf_cell, mpf_ctrl, maximal_pattern_filter and the testbench; no dependencies
`default_nettype none

package mpf_pkg;

   localparam int ROW_BITS = 32;   // columns of a pattern row that take part
   localparam int MAX_ROWS = 64;   // cells in the chain

   localparam int ROW_W   = 32;    // row_bits / kept_row field width
   localparam int PAT_W   = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
   localparam int TUSER_W = 2;

   // rsp tuser bit positions
   localparam int USER_EMPTY    = 0;
   localparam int USER_OVERFLOW = 1;

   typedef logic [PAT_W-1:0] pat_type;

   typedef enum logic [2:0] {
      OP_HOLD  = 3'd0,
      OP_CMP   = 3'd1,
      OP_CLR   = 3'd2,
      OP_SWAP  = 3'd3,
      OP_APP   = 3'd4,
      OP_SHIFT = 3'd5
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    phase;   // swap pairs start at even cells when 0, odd cells when 1
      pat_type row;
   } cell_ctrl_type;

   typedef struct packed {
      logic    any_sup;   // some cell strictly covers the row
      logic    packed_ok; // valid cells form an unbroken run from cell 0
      logic    full;
      logic    head_vld;
      logic    next_vld;
      pat_type head_pat;
   } chain_status_type;

endpackage

`default_nettype wire

[hw/rtl/mpf_cell.sv]
// mpf_cell: one storage cell of the pattern chain
// holds a row and its valid bit, compares against the broadcast row; uses mpf_pkg
`default_nettype none

module mpf_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  mpf_pkg::cell_ctrl_type ctrl,
   input  wire                    cell_odd,
   input  wire                    lo_vld,
   input  wire                    up_vld,
   input  mpf_pkg::pat_type       up_pat,
   output logic                   vld,
   output mpf_pkg::pat_type       pat,
   output logic                   sup
);
   import mpf_pkg::*;

   logic    vld_ff, vld_in;
   pat_type pat_ff, pat_in;
   logic    sup_ff, sup_in;
   logic    sub_ff, sub_in;
   logic    lower;

   assign lower = (cell_odd == ctrl.phase);

   always_comb begin
      vld_in = vld_ff;
      pat_in = pat_ff;
      sup_in = sup_ff;
      sub_in = sub_ff;
      case (ctrl.op)
         OP_CMP: begin
            sup_in = vld_ff && (pat_ff != ctrl.row) && ((ctrl.row & ~pat_ff) == '0);
            sub_in = vld_ff && ((pat_ff & ~ctrl.row) == '0);
         end
         OP_CLR: begin
            if (sub_ff) begin
               vld_in = 1'b0;
            end
         end
         OP_SWAP: begin
            // a hole below a valid cell trades places with it
            if (lower) begin
               if (!vld_ff && up_vld) begin
                  vld_in = 1'b1;
                  pat_in = up_pat;
               end
            end else begin
               if (vld_ff && !lo_vld) begin
                  vld_in = 1'b0;
               end
            end
         end
         OP_APP: begin
            if (!vld_ff && lo_vld) begin
               vld_in = 1'b1;
               pat_in = ctrl.row;
            end
         end
         OP_SHIFT: begin
            vld_in = up_vld;
            pat_in = up_pat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         sup_ff <= 1'b0;
         sub_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         sup_ff <= sup_in;
         sub_ff <= sub_in;
      end
      pat_ff <= pat_in;
   end

   assign vld = vld_ff;
   assign pat = pat_ff;
   assign sup = sup_ff;

endmodule

`default_nettype wire

[hw/rtl/mpf_ctrl.sv]
// mpf_ctrl: sequencer and output register of the maximal pattern filter
// drives the cell chain commands from chain status; uses mpf_pkg
`default_nettype none

module mpf_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [mpf_pkg::ROW_W-1:0]    req_tdata,   // row_bits
   input  wire                          req_tlast,   // last_row
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [mpf_pkg::ROW_W-1:0]    rsp_tdata,   // kept_row
   output logic                         rsp_tlast,   // last_out
   output logic [mpf_pkg::TUSER_W-1:0]  rsp_tuser,   // empty_set, overflow
   input  mpf_pkg::chain_status_type    status,
   output mpf_pkg::cell_ctrl_type       cell_ctrl
);
   import mpf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CMP   = 5'b00010,
      ST_CLR   = 5'b00100,
      ST_PACK  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   pat_type            row_ff, row_in;
   logic               last_ff, last_in;
   logic               phase_ff, phase_in;
   logic               over_ff, over_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [ROW_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [TUSER_W-1:0] rsp_user_ff, rsp_user_in;
   op_type             op;
   logic               out_free;
   state_type          done_state;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign done_state = last_ff ? ST_DRAIN : ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      last_in     = last_ff;
      phase_in    = phase_ff;
      over_in     = over_ff;
      rsp_vld_in  = out_free ? 1'b0 : rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_user_in = rsp_user_ff;
      op          = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               row_in  = req_tdata[PAT_W-1:0];
               last_in = req_tlast;
               if (req_tdata[PAT_W-1:0] != '0) begin
                  state_in = ST_CMP;
               end else if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_CMP: begin
            op       = OP_CMP;
            state_in = ST_CLR;
         end
         ST_CLR: begin
            if (status.any_sup) begin
               state_in = done_state;
            end else begin
               op       = OP_CLR;
               phase_in = 1'b0;
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (status.packed_ok) begin
               if (status.full) begin
                  over_in = 1'b1;
               end else begin
                  op = OP_APP;
               end
               state_in = done_state;
            end else begin
               op       = OP_SWAP;
               phase_in = !phase_ff;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_vld_in                = 1'b1;
               rsp_user_in[USER_OVERFLOW] = over_ff;
               if (status.head_vld) begin
                  op                     = OP_SHIFT;
                  rsp_data_in            = ROW_W'(status.head_pat);
                  rsp_last_in            = !status.next_vld;
                  rsp_user_in[USER_EMPTY] = 1'b0;
                  if (!status.next_vld) begin
                     over_in  = 1'b0;
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_data_in            = '0;
                  rsp_last_in            = 1'b1;
                  rsp_user_in[USER_EMPTY] = 1'b1;
                  over_in                = 1'b0;
                  state_in               = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= 1'b0;
         over_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         over_ff    <= over_in;
         rsp_vld_ff <= rsp_vld_in;
         last_ff    <= last_in;
      end
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready      = (state_ff == ST_IDLE);
   assign rsp_tvalid      = rsp_vld_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tlast       = rsp_last_ff;
   assign rsp_tuser       = rsp_user_ff;
   assign cell_ctrl.op    = op;
   assign cell_ctrl.phase = phase_ff;
   assign cell_ctrl.row   = row_ff;

endmodule

`default_nettype wire

[hw/rtl/maximal_pattern_filter.sv]
// maximal_pattern_filter: keeps the maximal row patterns of a set, drains them after the last row
// a zero row is only taken, a row that a stored row covers passes compare and clear only, any other
// row also passes compaction steps (odd-even exchange along the cell chain) before it is appended
// results drain one word a cycle from cell 0 after the last row, while the output is not stalled
// reset (synchronous, active high) empties every cell and clears the overflow flag
`default_nettype none

module maximal_pattern_filter (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [mpf_pkg::ROW_W-1:0]    req_tdata,   // [31:0] row_bits
   input  wire                          req_tlast,   // last_row
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [mpf_pkg::ROW_W-1:0]    rsp_tdata,   // [31:0] kept_row
   output logic                         rsp_tlast,   // last_out
   output logic [mpf_pkg::TUSER_W-1:0]  rsp_tuser    // [0] empty_set, [1] overflow
);
   import mpf_pkg::*;

   cell_ctrl_type    cell_ctrl;
   chain_status_type status;
   logic [MAX_ROWS-1:0] vld_vec;
   logic [MAX_ROWS-1:0] sup_vec;
   pat_type             pat_arr [MAX_ROWS];

   mpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .status     (status),
      .cell_ctrl  (cell_ctrl)
   );

   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
      logic    lo_vld;
      logic    up_vld;
      pat_type up_pat;

      if (k == 0) begin : g_lo_edge
         assign lo_vld = 1'b1;
      end else begin : g_lo
         assign lo_vld = vld_vec[k-1];
      end

      if (k == MAX_ROWS - 1) begin : g_up_edge
         assign up_vld = 1'b0;
         assign up_pat = '0;
      end else begin : g_up
         assign up_vld = vld_vec[k+1];
         assign up_pat = pat_arr[k+1];
      end

      mpf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .cell_odd ((k % 2 == 1) ? 1'b1 : 1'b0),
         .lo_vld   (lo_vld),
         .up_vld   (up_vld),
         .up_pat   (up_pat),
         .vld      (vld_vec[k]),
         .pat      (pat_arr[k]),
         .sup      (sup_vec[k])
      );
   end

   assign status.any_sup   = |sup_vec;
   assign status.packed_ok = ~|(~vld_vec[MAX_ROWS-2:0] & vld_vec[MAX_ROWS-1:1]);
   assign status.full      = vld_vec[MAX_ROWS-1];
   assign status.head_vld  = vld_vec[0];
   assign status.next_vld  = vld_vec[1];
   assign status.head_pat  = pat_arr[0];

`ifndef SYNTHESIS
   // between rows the stored patterns always sit in an unbroken run from cell 0
   a_packed_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> status.packed_ok)
      else $error("cell chain has a hole while idle");

   // the empty-set word is a lone final word with a zero row
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_EMPTY] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty-set word malformed");

   // a row is appended only when no cell strictly covers it and the chain is not full
   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == OP_APP) |-> !status.any_sup && !status.full)
      else $error("row appended while dominated or chain full");
`endif

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for maximal_pattern_filter, rows in, maximal rows out
// depends on mpf_pkg and maximal_pattern_filter; a directed table, then random runs
// checked word by word against an in-bench model of the antichain filter
`timescale 1ns / 1ps

module testbench;
   import mpf_pkg::*;

   localparam int RANDOM_ROWS = 300;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 80;
   localparam int IDLE_LIMIT  = 2000;

   typedef enum int {RUN_MIXED, RUN_NOISE, RUN_FILL} run_kind_type;

   typedef struct packed {
      logic [ROW_W-1:0] kept;
      logic             last;
      logic             empty;
      logic             over;
   } kept_word_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic             last;
      logic             typed;        // result of this last row is written in the table
      logic [ROW_W-1:0] want_kept;
      logic             want_empty;
   } plan_row_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ROW_W-1:0]    req_tdata  = '0;     // [31:0] row_bits
   logic                req_tlast  = 1'b0;   // last_row
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [ROW_W-1:0]    rsp_tdata;           // [31:0] kept_row
   logic                rsp_tlast;           // last_out
   logic [TUSER_W-1:0]  rsp_tuser;           // [0] empty_set, [1] overflow

   kept_word_type expected_kept[$];
   plan_row_type  directed_rows[$];
   pat_type       held_rows[$];
   bit            dropped_for_room = 1'b0;
   int            mismatches       = 0;
   int            rows_offered     = 0;
   int            idle_cycles      = 0;
   bit            hold_rsp         = 1'b0;
   bit            req_calm         = 1'b0;
   bit            rsp_calm         = 1'b0;

   maximal_pattern_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                  input logic [ROW_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // keeps the stored rows an antichain; on the last row queues the survivors
   function automatic void filter_row(input logic [ROW_W-1:0] word, input logic last_row,
                                      input logic typed);
      pat_type       r;
      pat_type       survivors[$];
      bit            covered;
      kept_word_type w;
      r = word[PAT_W-1:0];
      covered = 1'b0;
      if (r != '0) begin
         foreach (held_rows[k])
            if (held_rows[k] != r && (r & ~held_rows[k]) == '0) covered = 1'b1;
         if (!covered) begin
            // equal rows go too, so the newest copy ends up at the tail
            foreach (held_rows[k])
               if ((held_rows[k] & ~r) != '0) survivors = {survivors, held_rows[k]};
            held_rows = survivors;
            if (held_rows.size() >= MAX_ROWS) dropped_for_room = 1'b1;
            else held_rows = {held_rows, r};
         end
      end
      if (last_row && !typed) begin
         if (held_rows.size() == 0) begin
            w = '0;
            w.last  = 1'b1;
            w.empty = 1'b1;
            w.over  = dropped_for_room;
            expected_kept = {expected_kept, w};
         end else begin
            foreach (held_rows[k]) begin
               w = '0;
               w.kept[PAT_W-1:0] = held_rows[k];
               w.last = (k == held_rows.size() - 1);
               w.over = dropped_for_room;
               expected_kept = {expected_kept, w};
            end
         end
      end
      if (last_row) begin
         held_rows.delete();
         dropped_for_room = 1'b0;
      end
   endfunction

   task automatic send_row(input plan_row_type s);
      int            gap;
      kept_word_type w;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s.row;
      req_tlast  <= s.last;
      do @(posedge clock); while (req_tready !== 1'b1);
      filter_row(s.row, s.last, s.typed);
      if (s.last && s.typed) begin
         w = {s.want_kept, 1'b1, s.want_empty, 1'b0};
         expected_kept = {expected_kept, w};
      end
      rows_offered++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_kept.size() != 0);
   endtask

   function automatic void add_directed(input logic [ROW_W-1:0] r, input logic l,
                                        input logic t, input logic [ROW_W-1:0] k,
                                        input logic e);
      plan_row_type p;
      p = {r, l, t, k, e};
      directed_rows = {directed_rows, p};
   endfunction

   task automatic random_run(input run_kind_type kind);
      logic [ROW_W-1:0] sent[$];
      logic [ROW_W-1:0] r;
      int               len;
      int               pick;
      len = (kind == RUN_FILL) ? $urandom_range(66, 72) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         case (kind)
            RUN_FILL: begin
               // rows of equal weight never cover each other, so the cells fill up
               r = '0;
               while ($countones(r) < 3) r[$urandom_range(0, ROW_W - 1)] = 1'b1;
               if (pick == 0) r = $urandom;
            end
            RUN_NOISE: r = $urandom;
            default: begin
               if (sent.size() == 0 && pick >= 1 && pick <= 4) pick = 9;
               case (pick)
                  0:       r = '0;
                  1, 2:    r = sent[$urandom_range(0, sent.size() - 1)] & $urandom;
                  3:       r = sent[$urandom_range(0, sent.size() - 1)]
                               | (32'h1 << $urandom_range(0, ROW_W - 1));
                  4:       r = sent[$urandom_range(0, sent.size() - 1)];
                  5, 6:    r = $urandom & $urandom & $urandom;
                  7:       r = $urandom | $urandom;
                  default: r = $urandom;
               endcase
            end
         endcase
         send_row({r, (i == len - 1) ? 1'b1 : 1'b0, 1'b0, {ROW_W{1'b0}}, 1'b0});
         sent = {sent, r};
      end
   endtask

   // result side: random stalls per word, one long hold-off on request
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = rsp_calm ? 0 : $urandom_range(0, 9);
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      kept_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_kept.size() == 0) begin
            report_mismatch("word with nothing due, kept_row", rsp_tdata, '0);
         end else begin
            want = expected_kept.pop_front();
            if (rsp_tdata !== want.kept) report_mismatch("kept_row", rsp_tdata, want.kept);
            if (rsp_tlast !== want.last)
               report_mismatch("last_out", ROW_W'(rsp_tlast), ROW_W'(want.last));
            if (rsp_tuser[USER_EMPTY] !== want.empty)
               report_mismatch("empty_set", ROW_W'(rsp_tuser[USER_EMPTY]),
                               ROW_W'(want.empty));
            if (rsp_tuser[USER_OVERFLOW] !== want.over)
               report_mismatch("overflow", ROW_W'(rsp_tuser[USER_OVERFLOW]),
                               ROW_W'(want.over));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: %0d words still due", expected_kept.size());
         $display("FAIL maximal_pattern_filter");
         $finish;
      end
   end

   initial begin
      int fills;
      fills = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single-row runs: empty set and extremes
      add_directed(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
      add_directed(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
      add_directed(32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b0);
      add_directed(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0);
      // subset dropped, equal row moves to the tail, zero row skipped, cover removes two
      add_directed(32'h0000_000F, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0003, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_00F0, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_000F, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0F00_0000, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0000, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0FFF, 1'b1, 1'b0, '0, 1'b0);
      // zero row carrying the last mark still ends the run
      add_directed(32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h5555_5555, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0000, 1'b1, 1'b0, '0, 1'b0);
      // growing chain, repeated row, strict subset as the last row
      add_directed(32'h0000_0001, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0003, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0007, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      add_directed(32'h0000_0007, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0007, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      add_directed(32'h1234_5678, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0);
      add_directed(32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);

      foreach (directed_rows[i]) send_row(directed_rows[i]);
      wait_drained();

      // long result stall while a full run is offered, so the input backs up
      hold_rsp = 1'b1;
      random_run(RUN_FILL);
      fills++;
      while (rows_offered < directed_rows.size() + RANDOM_ROWS) begin
         if (fills < 2 && rows_offered > directed_rows.size() + RANDOM_ROWS / 2) begin
            random_run(RUN_FILL);
            fills++;
         end else begin
            random_run(($urandom_range(0, 4) == 0) ? RUN_NOISE : RUN_MIXED);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_kept.size() == 0) begin
         $display("PASS maximal_pattern_filter");
      end else begin
         $display("FAIL maximal_pattern_filter");
      end
      $finish;
   end

endmodule
